FILE: hw/rtl/art_pkg.sv
package art_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int S_FIELDS_W = 64 + 64 + 64 + 2 + 32 + 64;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 2 + 1 + 4 + 32 + 32 + 33 + 2 + 32;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [32:0] SPACE_TOP = 33'h1_0000_0000;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_FIND = 1'b1;

    localparam logic [1:0] KIND_RAM     = 2'd0;
    localparam logic [1:0] KIND_GUARD   = 2'd1;
    localparam logic [1:0] KIND_MMIO    = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_OVERLAP = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } art_state_t;

    typedef struct packed {
        logic        is_find;
        logic        bad;
        logic [31:0] base;
        logic [31:0] phys;
        logic [32:0] len;
        logic [32:0] n_end;
        logic [1:0]  kind;
        logic [31:0] attrs;
        logic [31:0] addr;
        logic        addr_high;
    } art_cmd_t;

    typedef struct packed {
        logic [31:0] attrs;
        logic [1:0]  kind;
        logic [32:0] len;
        logic [31:0] phys;
        logic [31:0] base;
    } art_entry_t;

    typedef struct packed {
        logic [31:0] hit_attrs;
        logic [1:0]  hit_kind;
        logic [32:0] hit_length;
        logic [31:0] hit_phys;
        logic [31:0] hit_base;
        logic [3:0]  hit_index;
        logic        hit;
        logic [1:0]  status;
    } art_result_t;

endpackage

FILE: hw/rtl/art_ram.sv
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic                                           re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/art_front.sv
module art_front (
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [art_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output art_pkg::art_cmd_t              q_data
);

    logic [63:0] base;
    logic [63:0] phys;
    logic [63:0] len;
    logic [1:0]  kind;
    logic [31:0] attrs;
    logic [63:0] addr;
    logic [32:0] n_end;
    logic [32:0] p_end;
    logic        len_ok;
    logic        base_ok;
    logic        ram_ok;
    logic        kind_ok;

    assign base  = s_tdata[63:0];
    assign phys  = s_tdata[127:64];
    assign len   = s_tdata[191:128];
    assign kind  = s_tdata[193:192];
    assign attrs = s_tdata[225:194];
    assign addr  = s_tdata[289:226];

    // Both bases are below 4 GiB and the length at most 4 GiB when these sums matter,
    // so 33 bits never wrap.
    assign n_end = {1'b0, base[31:0]} + len[32:0];
    assign p_end = {1'b0, phys[31:0]} + len[32:0];

    assign len_ok = (len != 64'd0) && (len[art_pkg::PAGE_BITS-1:0] == '0)
                 && (len[63:33] == '0) && (!len[32] || (len[31:0] == 32'd0));
    assign base_ok = (base[art_pkg::PAGE_BITS-1:0] == '0) && (base[63:32] == 32'd0)
                  && (n_end <= art_pkg::SPACE_TOP);
    assign ram_ok = (kind != art_pkg::KIND_RAM)
                 || ((phys[art_pkg::PAGE_BITS-1:0] == '0) && (phys[63:32] == 32'd0)
                     && (p_end <= art_pkg::SPACE_TOP));
    assign kind_ok = (kind != art_pkg::KIND_INVALID);

    always_comb begin
        q_data.is_find   = (s_tuser == art_pkg::CMD_FIND);
        q_data.bad       = !(len_ok && base_ok && ram_ok && kind_ok);
        q_data.base      = base[31:0];
        q_data.phys      = phys[31:0];
        q_data.len       = len[32:0];
        q_data.n_end     = n_end;
        q_data.kind      = kind;
        q_data.attrs     = attrs;
        q_data.addr      = addr[31:0];
        q_data.addr_high = (addr[63:32] != 32'd0);
    end

    assign s_tready = aresetn && !q_full;
    assign q_push   = s_tvalid && s_tready;

endmodule

FILE: hw/rtl/art_queue.sv
module art_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  art_pkg::art_cmd_t    push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output art_pkg::art_cmd_t    pop_data
);

    art_pkg::art_cmd_t               slot_reg [art_pkg::QUEUE_DEPTH];
    logic [art_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [art_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [art_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [art_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [art_pkg::QCNT_W-1:0]      fill_reg;
    logic [art_pkg::QCNT_W-1:0]      fill_next;

    assign full     = (fill_reg == art_pkg::QCNT_W'(art_pkg::QUEUE_DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == art_pkg::QPTR_W'(art_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == art_pkg::QPTR_W'(art_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/art_back.sv
module art_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  art_pkg::art_cmd_t              q_data,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [art_pkg::M_TDATA_W-1:0]  m_tdata
);

    art_pkg::art_state_t          state_reg;
    art_pkg::art_state_t          state_next;
    art_pkg::art_cmd_t            cur_reg;
    art_pkg::art_cmd_t            cur_next;
    logic [art_pkg::CNT_W-1:0]    count_reg;
    logic [art_pkg::CNT_W-1:0]    count_next;
    logic [art_pkg::CNT_W-1:0]    idx_reg;
    logic [art_pkg::CNT_W-1:0]    idx_next;
    logic                         chk_valid_reg;
    logic                         chk_valid_next;
    logic [art_pkg::IDX_W-1:0]    chk_idx_reg;
    logic [art_pkg::IDX_W-1:0]    chk_idx_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    art_pkg::art_result_t         out_reg;
    art_pkg::art_result_t         out_next;

    logic                         slot_free;
    logic                         ram_we;
    logic [art_pkg::IDX_W-1:0]    ram_waddr;
    art_pkg::art_entry_t          ram_wdata;
    logic                         ram_re;
    logic [$bits(art_pkg::art_entry_t)-1:0] ram_rdata;
    art_pkg::art_entry_t          ent;
    logic [32:0]                  e_end;
    logic                         match;
    logic                         last;
    logic                         table_full;
    logic                         finish;

    art_ram #(
        .WIDTH ($bits(art_pkg::art_entry_t)),
        .DEPTH (art_pkg::MAX_REGIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[art_pkg::IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ent   = art_pkg::art_entry_t'(ram_rdata);
    assign e_end = {1'b0, ent.base} + ent.len;

    // A find hit needs e_base <= addr < e_end; an add conflicts when the two spans intersect.
    assign match = cur_reg.is_find
                 ? (!cur_reg.addr_high && (cur_reg.addr >= ent.base)
                    && ({1'b0, cur_reg.addr} < e_end))
                 : (({1'b0, ent.base} < cur_reg.n_end) && ({1'b0, cur_reg.base} < e_end));
    assign last       = ((art_pkg::CNT_W'(chk_idx_reg) + art_pkg::CNT_W'(1)) == count_reg);
    assign table_full = (count_reg >= art_pkg::CNT_W'(art_pkg::MAX_REGIONS));
    assign slot_free  = !out_valid_reg || m_tready;
    assign q_pop      = (state_reg == art_pkg::ST_IDLE) && q_valid && slot_free;
    assign ram_re     = (state_reg == art_pkg::ST_SCAN) && (idx_reg < count_reg);
    assign finish     = (state_reg == art_pkg::ST_SCAN) && chk_valid_reg
                     && (match || last);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            art_pkg::ST_IDLE: begin
                if (q_pop && (count_reg != '0)
                    && (q_data.is_find || (!q_data.bad && !table_full))) begin
                    state_next = art_pkg::ST_SCAN;
                end
            end
            art_pkg::ST_SCAN: begin
                if (finish) begin
                    state_next = art_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = art_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[art_pkg::IDX_W-1:0];
        ram_wdata.base  = q_data.base;
        ram_wdata.phys  = q_data.phys;
        ram_wdata.len   = q_data.len;
        ram_wdata.kind  = q_data.kind;
        ram_wdata.attrs = q_data.attrs;
        unique case (state_reg)
            art_pkg::ST_IDLE: begin
                if (q_pop) begin
                    cur_next = q_data;
                    idx_next = '0;
                    out_next = '0;
                    if (!q_data.is_find) begin
                        priority if (q_data.bad) begin
                            out_valid_next = 1'b1;
                            out_next.status = art_pkg::STATUS_INVALID;
                        end else if (table_full) begin
                            out_valid_next = 1'b1;
                            out_next.status = art_pkg::STATUS_FULL;
                        end else if (count_reg == '0) begin
                            out_valid_next = 1'b1;
                            out_next.status = art_pkg::STATUS_OK;
                            ram_we = 1'b1;
                            count_next = count_reg + 1'b1;
                        end else begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    end else if (count_reg == '0) begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            art_pkg::ST_SCAN: begin
                ram_wdata.base  = cur_reg.base;
                ram_wdata.phys  = cur_reg.phys;
                ram_wdata.len   = cur_reg.len;
                ram_wdata.kind  = cur_reg.kind;
                ram_wdata.attrs = cur_reg.attrs;
                if (ram_re) begin
                    idx_next       = idx_reg + 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[art_pkg::IDX_W-1:0];
                end
                if (finish) begin
                    chk_valid_next = 1'b0;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (match) begin
                        if (cur_reg.is_find) begin
                            out_next.hit        = 1'b1;
                            out_next.hit_index  = 4'(chk_idx_reg);
                            out_next.hit_base   = ent.base;
                            out_next.hit_phys   = ent.phys;
                            out_next.hit_length = ent.len;
                            out_next.hit_kind   = ent.kind;
                            out_next.hit_attrs  = ent.attrs;
                        end else begin
                            out_next.status = art_pkg::STATUS_OVERLAP;
                        end
                    end else if (!cur_reg.is_find) begin
                        out_next.status = art_pkg::STATUS_OK;
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default: begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= art_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        chk_idx_reg <= chk_idx_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(art_pkg::M_TDATA_W - art_pkg::M_FIELDS_W){1'b0}}, out_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= art_pkg::CNT_W'(art_pkg::MAX_REGIONS))
        else $error("Entry count exceeds the table size.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !table_full)
        else $error("Table write while the table is full.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        chk_valid_reg |-> (art_pkg::CNT_W'(chk_idx_reg) < count_reg))
        else $error("Scan checks an entry at or above the count.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish || q_pop) |-> slot_free)
        else $error("Result loaded while the output register still holds an item.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Table write without a count increment.");

endmodule

FILE: hw/rtl/address_region_table.sv
// Guest address region table with an overlap check.
// The slave channel takes one command item per handshake: s_tuser selects add (0) or
// find (1), and s_tdata carries the candidate region and the lookup address.
// The master channel returns exactly one result item per command: a status, and for
// a find the first stored region that contains the address, or a miss.
// Commands pass through a two-item queue into a scan engine. An add that is invalid,
// hits a full table, or meets an empty table, and a find on an empty table, return
// their result without a scan. Any other command scans the stored regions in index
// order, one entry per cycle through the table RAM read port, and returns once it
// finds a match or has examined the last entry. The scan engine takes the next
// command from the queue only when it is idle and the output register is free.
// A result waits in an output register; while it is stalled the queue keeps
// accepting items until it is full, then s_tready drops.
// Reset empties the table and the queue and drops any pending result.
module address_region_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // base_address[63:0], phys_address[127:64], region_length[191:128],
    // region_kind[193:192], region_attrs[225:194], lookup_address[289:226], zero pad.
    input  logic [art_pkg::S_TDATA_W-1:0]  s_tdata,
    // command.
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], hit[2], hit_index[6:3], hit_base[38:7], hit_phys[70:39],
    // hit_length[103:71], hit_kind[105:104], hit_attrs[137:106], zero pad.
    output logic [art_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic               q_full;
    logic               q_push;
    art_pkg::art_cmd_t  q_in;
    logic               q_pop;
    logic               q_valid;
    art_pkg::art_cmd_t  q_out;

    art_front u_front (
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    art_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    art_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: tb/address_region_table_tb.sv
module address_region_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import art_pkg::*;

    localparam logic [63:0] GUEST_TOP    = 64'h1_0000_0000;
    localparam logic [63:0] LOW_WORD     = 64'hFFFF_FFFF;
    localparam logic [63:0] PAGE         = 64'(PAGE_BYTES);
    localparam logic [63:0] PAGE_MASK    = 64'(PAGE_BYTES - 1);
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          IDLE_LIMIT   = 1000;
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        logic        cmd;
        logic [63:0] base;
        logic [63:0] phys;
        logic [63:0] len;
        logic [1:0]  kind;
        logic [31:0] attrs;
        logic [63:0] addr;
    } region_cmd_t;

    class region_table_model;
        logic [63:0] ent_base[MAX_REGIONS];
        logic [63:0] ent_phys[MAX_REGIONS];
        logic [63:0] ent_len[MAX_REGIONS];
        logic [1:0]  ent_kind[MAX_REGIONS];
        logic [31:0] ent_attrs[MAX_REGIONS];
        int          entry_total;
        int          mismatches;
        art_result_t pending_results[$];

        function new();
            entry_total = 0;
            mismatches  = 0;
        endfunction

        function bit fits_space(logic [63:0] start, logic [63:0] size);
            if (start > LOW_WORD || size > GUEST_TOP) begin
                return 1'b0;
            end
            return start <= GUEST_TOP - size;
        endfunction

        function bit region_valid(region_cmd_t c);
            if (c.len == 0 || (c.base & PAGE_MASK) != 0 || (c.len & PAGE_MASK) != 0) begin
                return 1'b0;
            end
            if (!fits_space(c.base, c.len)) begin
                return 1'b0;
            end
            if (c.kind == KIND_RAM && ((c.phys & PAGE_MASK) != 0 || !fits_space(c.phys, c.len))) begin
                return 1'b0;
            end
            return c.kind != KIND_INVALID;
        endfunction

        function art_result_t apply_command(region_cmd_t c);
            art_result_t r;
            bit          found;
            r     = '0;
            found = 1'b0;
            if (c.cmd == CMD_ADD) begin
                if (!region_valid(c)) begin
                    r.status = STATUS_INVALID;
                end else if (entry_total >= MAX_REGIONS) begin
                    r.status = STATUS_FULL;
                end else begin
                    r.status = STATUS_OK;
                    for (int i = 0; i < entry_total; i++) begin
                        if (ent_base[i] < c.base + c.len && c.base < ent_base[i] + ent_len[i]) begin
                            r.status = STATUS_OVERLAP;
                        end
                    end
                    if (r.status == STATUS_OK) begin
                        ent_base[entry_total]  = c.base & LOW_WORD;
                        ent_phys[entry_total]  = c.phys & LOW_WORD;
                        ent_len[entry_total]   = c.len;
                        ent_kind[entry_total]  = c.kind;
                        ent_attrs[entry_total] = c.attrs;
                        entry_total++;
                    end
                end
            end else begin
                for (int i = 0; i < entry_total; i++) begin
                    if (!found && c.addr >= ent_base[i] && c.addr - ent_base[i] < ent_len[i]) begin
                        found        = 1'b1;
                        r.hit        = 1'b1;
                        r.hit_index  = 4'(i);
                        r.hit_base   = ent_base[i][31:0];
                        r.hit_phys   = ent_phys[i][31:0];
                        r.hit_length = ent_len[i][32:0];
                        r.hit_kind   = ent_kind[i];
                        r.hit_attrs  = ent_attrs[i];
                    end
                end
            end
            return r;
        endfunction

        function void note_command(region_cmd_t c);
            pending_results.push_back(apply_command(c));
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
            mismatches++;
        endtask

        task check_result(art_result_t got);
            art_result_t want;
            if (pending_results.size() == 0) begin
                report("result with no command waiting", 64'(got.status), 64'(0));
                return;
            end
            want = pending_results.pop_front();
            if (got.status != want.status) begin
                report("status", 64'(got.status), 64'(want.status));
            end
            if (got.hit != want.hit) begin
                report("hit", 64'(got.hit), 64'(want.hit));
            end
            if (got.hit_index != want.hit_index) begin
                report("hit_index", 64'(got.hit_index), 64'(want.hit_index));
            end
            if (got.hit_base != want.hit_base) begin
                report("hit_base", 64'(got.hit_base), 64'(want.hit_base));
            end
            if (got.hit_phys != want.hit_phys) begin
                report("hit_phys", 64'(got.hit_phys), 64'(want.hit_phys));
            end
            if (got.hit_length != want.hit_length) begin
                report("hit_length", 64'(got.hit_length), 64'(want.hit_length));
            end
            if (got.hit_kind != want.hit_kind) begin
                report("hit_kind", 64'(got.hit_kind), 64'(want.hit_kind));
            end
            if (got.hit_attrs != want.hit_attrs) begin
                report("hit_attrs", 64'(got.hit_attrs), 64'(want.hit_attrs));
            end
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    region_table_model model;
    int                sent_items  = 0;
    int                idle_cycles = 0;

    address_region_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(region_cmd_t c);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[S_FIELDS_W-1:0] = {c.addr, c.attrs, c.kind, c.len, c.phys, c.base};
        gap = (sent_items % 200 < 40) ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= c.cmd;
        do @(posedge aclk); while (!s_tready);
        model.note_command(c);
        sent_items++;
    endtask

    task automatic receive_results();
        int stall;
        int taken;
        taken = 0;
        forever begin
            stall = (taken % 150 < 30) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            model.check_result(art_result_t'(m_tdata[M_FIELDS_W-1:0]));
            taken++;
        end
    endtask

    function automatic region_cmd_t make_cmd(logic cmd, logic [63:0] base, logic [63:0] phys,
                                             logic [63:0] len, logic [1:0] kind,
                                             logic [31:0] attrs, logic [63:0] addr);
        region_cmd_t c;
        c.cmd   = cmd;
        c.base  = base;
        c.phys  = phys;
        c.len   = len;
        c.kind  = kind;
        c.attrs = attrs;
        c.addr  = addr;
        return c;
    endfunction

    function automatic region_cmd_t noise_item();
        region_cmd_t c;
        c.cmd   = 1'($urandom_range(0, 1));
        c.base  = {$urandom(), $urandom()};
        c.phys  = {$urandom(), $urandom()};
        c.len   = {$urandom(), $urandom()};
        c.kind  = 2'($urandom_range(0, 3));
        c.attrs = $urandom();
        c.addr  = {$urandom(), $urandom()};
        return c;
    endfunction

    function automatic region_cmd_t fresh_region();
        region_cmd_t c;
        int          e;
        int          pages;
        c = noise_item();
        c.cmd = CMD_ADD;
        pages = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536) : $urandom_range(1, 16);
        c.len = 64'(pages) << PAGE_BITS;
        if (model.entry_total > 0 && $urandom_range(0, 1) == 1) begin
            e = $urandom_range(0, model.entry_total - 1);
            c.base = model.ent_base[e] + model.ent_len[e];
        end else begin
            c.base = {32'h0, $urandom()} & ~PAGE_MASK;
        end
        c.kind = 2'($urandom_range(0, 2));
        if (c.kind == KIND_RAM) begin
            c.phys = {32'h0, $urandom()} & ~PAGE_MASK;
        end
        return c;
    endfunction

    function automatic region_cmd_t overlap_region();
        region_cmd_t c;
        int          e;
        int          span;
        int          k;
        c = fresh_region();
        e = $urandom_range(0, model.entry_total - 1);
        span = int'(model.ent_len[e] >> PAGE_BITS);
        if ($urandom_range(0, 1) == 1) begin
            c.base = model.ent_base[e] + (64'($urandom_range(0, span - 1)) << PAGE_BITS);
            c.len  = 64'($urandom_range(1, 8)) << PAGE_BITS;
        end else begin
            k = $urandom_range(1, 8);
            if (model.ent_base[e] < (64'(k) << PAGE_BITS)) begin
                k = 0;
            end
            c.base = model.ent_base[e] - (64'(k) << PAGE_BITS);
            c.len  = 64'(k + $urandom_range(1, 4)) << PAGE_BITS;
        end
        return c;
    endfunction

    function automatic region_cmd_t broken_region();
        region_cmd_t c;
        c = fresh_region();
        case ($urandom_range(0, 8))
            0: c.len = '0;
            1: c.base = c.base | 64'($urandom_range(1, PAGE_BYTES - 1));
            2: c.len = c.len | 64'($urandom_range(1, PAGE_BYTES - 1));
            3: c.base[63:32] = $urandom() | (32'h1 << $urandom_range(0, 31));
            4: c.len = GUEST_TOP + (64'($urandom_range(1, 16)) << PAGE_BITS);
            5: c.kind = KIND_INVALID;
            6: begin
                c.kind = KIND_RAM;
                c.phys = c.phys | 64'($urandom_range(1, PAGE_BYTES - 1));
            end
            7: begin
                c.base = LOW_WORD & ~PAGE_MASK;
                c.len  = 64'($urandom_range(2, 16)) << PAGE_BITS;
            end
            default: begin
                c.kind = KIND_RAM;
                c.phys = ($urandom_range(0, 1) == 1) ? (LOW_WORD & ~PAGE_MASK)
                                                     : {$urandom() | 32'h1, $urandom()};
                c.len  = 64'($urandom_range(2, 16)) << PAGE_BITS;
            end
        endcase
        return c;
    endfunction

    function automatic region_cmd_t find_item();
        region_cmd_t c;
        int          e;
        int          pick;
        c = noise_item();
        c.cmd = CMD_FIND;
        pick = $urandom_range(0, 99);
        if (model.entry_total > 0 && pick < 75) begin
            e = $urandom_range(0, model.entry_total - 1);
            case (pick % 5)
                0: c.addr = model.ent_base[e];
                1: c.addr = model.ent_base[e] + model.ent_len[e] - 1;
                2: c.addr = model.ent_base[e] + model.ent_len[e];
                3: c.addr = model.ent_base[e] - 1;
                default: c.addr = model.ent_base[e] + 64'($urandom()) % model.ent_len[e];
            endcase
        end else if (pick < 90) begin
            c.addr = {32'h0, $urandom()};
        end
        return c;
    endfunction

    task automatic run_directed();
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h1000_0000));
        send_item(make_cmd(CMD_ADD, 64'h2000_0000, 0, 0, KIND_MMIO, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h2000_0800, 0, PAGE, KIND_GUARD, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h2000_0000, 0, PAGE + 1, KIND_MMIO, 0, 0));
        send_item(make_cmd(CMD_ADD, GUEST_TOP, 0, PAGE, KIND_MMIO, 0, 0));
        send_item(make_cmd(CMD_ADD, GUEST_TOP - PAGE, 0, 2 * PAGE, KIND_MMIO, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h2000_0000, 0, PAGE, KIND_INVALID, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h2000_0000, 64'h8000_0010, PAGE, KIND_RAM, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h2000_0000, GUEST_TOP - PAGE, 2 * PAGE, KIND_RAM, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h1000_0000, 64'h8000_0000, 16 * PAGE, KIND_RAM,
                           32'hFFFF_FFFF, 0));
        send_item(make_cmd(CMD_ADD, GUEST_TOP - PAGE, 64'hFFFF_FFFF_FFFF_F123, PAGE, KIND_GUARD,
                           32'h0, 0));
        send_item(make_cmd(CMD_ADD, 0, 64'h0000_0001_0000_0ABC, PAGE, KIND_MMIO,
                           32'hA5A5_5A5A, 0));
        send_item(make_cmd(CMD_ADD, 64'h1000_F000, 64'h9000_0000, PAGE, KIND_RAM, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h1001_0000, 0, 2 * PAGE, KIND_MMIO, 32'h5A5A_A5A5, 0));
        send_item(make_cmd(CMD_ADD, 0, 0, GUEST_TOP, KIND_GUARD, 0, 0));
        send_item(make_cmd(CMD_ADD, 64'h3000_0000, GUEST_TOP - 2 * PAGE, 2 * PAGE, KIND_RAM,
                           32'h1234_5678, 0));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h1000_0000));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h1000_FFFF));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h1001_0000));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'hFFFF_FFFF));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, GUEST_TOP));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'hFFFF_FFFF_1000_0000));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h0));
        send_item(make_cmd(CMD_FIND, 0, 0, 0, KIND_RAM, 0, 64'h2000));
    endtask

    task automatic run_random();
        int pick;
        int fresh_odds;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_item(find_item());
            end else if (pick < 55) begin
                send_item(noise_item());
            end else begin
                // Late in the run, push the table to full so the full status is reached.
                fresh_odds = (n > RANDOM_ITEMS * 3 / 4 && model.entry_total < MAX_REGIONS) ? 40 : 5;
                pick = $urandom_range(0, 99);
                if (pick < fresh_odds || model.entry_total == 0) begin
                    send_item(fresh_region());
                end else if (pick < 60) begin
                    send_item(overlap_region());
                end else begin
                    send_item(broken_region());
                end
            end
        end
    endtask

    initial begin
        model = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            receive_results();
        join_none
        run_directed();
        run_random();
        s_tvalid <= 1'b0;
        while (model.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (model.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
